// ===== rtl/core/ordered_array_list_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Ordered array list engine - assertion macros
// Shared property wrappers for the checker; clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define OALE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oale: check failed");

// next-cycle implication
`define OALE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oale: check failed");

`endif

// ===== rtl/core/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered array list engine - package
// Sizes, codes and the command bundle driven into the cell row.
// ----------------------------------------------------------------------------
package oale_pkg;

	localparam int CAPACITY = 128;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;
	localparam int GRP_SZ   = 8;
	localparam int GRP_W    = $clog2(GRP_SZ);
	localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_LOCATE = 2'd1,
		REQ_INSERT = 2'd2,
		REQ_DELETE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_EXEC,
		FS_SHIFT,
		FS_DONE
	} fsm_t;

	typedef struct packed {
		logic             hit_en;
		logic             match_mode;
		logic             ins_en;
		logic             del_en;
		logic [IDX_W-1:0] pos0;
		logic [IDX_W-1:0] count;
		logic [31:0]      value;
	} cell_cmd_t;

endpackage

// ===== rtl/core/oale_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered array list engine - list cell
// Holds one entry; shifts from either neighbour and flags a hit.
// ----------------------------------------------------------------------------
module oale_cell import oale_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  cell_cmd_t        cmd,
	input  logic [31:0]      left,
	input  logic [31:0]      right,
	output logic [31:0]      data_q,
	output logic             hit_q
);

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (idx > cmd.pos0) begin
				data_q <= left;
			end else if (idx == cmd.pos0) begin
				data_q <= cmd.value;
			end
		end else if (cmd.del_en && (idx >= cmd.pos0)) begin
			data_q <= right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.hit_en) begin
			if (cmd.match_mode) begin
				hit_q <= (data_q == cmd.value) && (idx < cmd.count);
			end else begin
				hit_q <= (idx == cmd.pos0);
			end
		end
	end

endmodule

// ===== rtl/core/oale_group.sv =====
// ----------------------------------------------------------------------------
// Ordered array list engine - hit group
// Registers the first flagged cell of a group and its entry.
// ----------------------------------------------------------------------------
module oale_group import oale_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [GRP_SZ-1:0]        hits,
	input  logic [GRP_SZ-1:0][31:0]  vals,
	output logic                     ghit_q,
	output logic [GRP_W-1:0]         gidx_q,
	output logic [31:0]              gval_q
);

	logic [GRP_W-1:0] sel;

	always_comb begin
		sel = '0;
		for (int j = GRP_SZ - 1; j >= 0; j--) begin
			if (hits[j]) begin
				sel = GRP_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghit_q <= 1'b0;
		end else if (load) begin
			ghit_q <= |hits;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gidx_q <= sel;
			gval_q <= vals[sel];
		end
	end

endmodule

// ===== rtl/core/ordered_array_list_engine_unit.sv =====
// Sequencing: each request walks the sequencer through compare, group
// search/shift and result, and the result step waits while a pending result
// is stalled; req_stall refuses a new request until the sequencer is idle.
// Reset: list length, sequencer and result valid clear at once; entry cells
// are not cleared (entries beyond the length are never read).
// ----------------------------------------------------------------------------
// Ordered array list engine - top level
// Row of entry cells with positional insert/delete shifting and a grouped
// first-hit search used for locate and for reading out deleted entries.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit import oale_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [7:0]         found_position,
	output logic signed [31:0] removed_value,
	output logic [7:0]         list_length
);

	fsm_t             state_q, state_nxt;
	req_t             type_q;
	logic [7:0]       pos_q;
	logic [31:0]      val_q;
	logic [CNT_W-1:0] count_q;
	status_t          stat_q;
	logic             ins_q, del_q;
	logic             rsp_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       found_q, length_q;
	logic [31:0]      removed_q;

	logic [IDX_W-1:0] pos_w, cnt_w;
	logic             ins_bad, del_bad, full;
	logic             accept, emit;
	cell_cmd_t        cmd;

	logic [31:0]      cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic [NGRP-1:0]  ghit;
	logic [GRP_W-1:0] gidx [NGRP];
	logic [31:0]      gval [NGRP];

	logic             fhit;
	logic [IDX_W-1:0] fidx;
	logic [31:0]      fval;

	assign req_stall = (state_q != FS_IDLE);
	assign accept    = req_valid && !req_stall;
	assign emit      = (state_q == FS_DONE) && (!rsp_valid_q || !rsp_stall);

	assign pos_w   = IDX_W'(pos_q);
	assign cnt_w   = IDX_W'(count_q);
	assign ins_bad = (pos_q == 8'd0) || (pos_w > cnt_w + IDX_W'(1));
	assign del_bad = (pos_q == 8'd0) || (pos_w > cnt_w);
	assign full    = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		cmd.hit_en     = (state_q == FS_EXEC);
		cmd.match_mode = (type_q == REQ_LOCATE);
		cmd.ins_en     = (state_q == FS_SHIFT) && ins_q;
		cmd.del_en     = (state_q == FS_SHIFT) && del_q;
		cmd.pos0       = pos_w - IDX_W'(1);
		cmd.count      = cnt_w;
		cmd.value      = val_q;
	end

	// cell row
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [31:0] lft, rgt;
		if (k == 0) begin : g_first
			assign lft = cell_data[k];
		end else begin : g_mid_l
			assign lft = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign rgt = cell_data[k];
		end else begin : g_mid_r
			assign rgt = cell_data[k+1];
		end
		oale_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(k)),
			.cmd    (cmd),
			.left   (lft),
			.right  (rgt),
			.data_q (cell_data[k]),
			.hit_q  (cell_hit[k])
		);
	end

	// first-hit search, group level
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		logic [GRP_SZ-1:0]       h;
		logic [GRP_SZ-1:0][31:0] v;
		for (genvar j = 0; j < GRP_SZ; j++) begin : g_lane
			if (g * GRP_SZ + j < CAPACITY) begin : g_used
				assign h[j] = cell_hit[g*GRP_SZ+j];
				assign v[j] = cell_data[g*GRP_SZ+j];
			end else begin : g_pad
				assign h[j] = 1'b0;
				assign v[j] = '0;
			end
		end
		oale_group u_group (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (state_q == FS_SHIFT),
			.hits   (h),
			.vals   (v),
			.ghit_q (ghit[g]),
			.gidx_q (gidx[g]),
			.gval_q (gval[g])
		);
	end

	always_comb begin
		fhit = 1'b0;
		fidx = '0;
		fval = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (ghit[g]) begin
				fhit = 1'b1;
				fidx = IDX_W'(g * GRP_SZ) + IDX_W'(gidx[g]);
				fval = gval[g];
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FS_IDLE:  if (accept) state_nxt = FS_EXEC;
			FS_EXEC:  state_nxt = FS_SHIFT;
			FS_SHIFT: state_nxt = FS_DONE;
			FS_DONE:  if (emit) state_nxt = FS_IDLE;
			default:  state_nxt = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			count_q     <= '0;
			ins_q       <= 1'b0;
			del_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == FS_EXEC) begin
				ins_q <= 1'b0;
				del_q <= 1'b0;
				unique case (type_q)
					REQ_CLEAR: count_q <= '0;
					REQ_INSERT: begin
						if (!ins_bad && !full) begin
							ins_q   <= 1'b1;
							count_q <= count_q + CNT_W'(1);
						end
					end
					REQ_DELETE: begin
						if (!del_bad) begin
							del_q   <= 1'b1;
							count_q <= count_q - CNT_W'(1);
						end
					end
					default: ;
				endcase
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req_t'(req_type);
			pos_q  <= position;
			val_q  <= value;
		end
		if (state_q == FS_EXEC) begin
			priority if (type_q == REQ_INSERT && ins_bad) begin
				stat_q <= ST_BAD_POS;
			end else if (type_q == REQ_INSERT && full) begin
				stat_q <= ST_FULL;
			end else if (type_q == REQ_DELETE && del_bad) begin
				stat_q <= ST_BAD_POS;
			end else begin
				stat_q <= ST_OK;
			end
		end
		if (emit) begin
			length_q <= 8'(count_q);
			if (type_q == REQ_LOCATE) begin
				status_q  <= fhit ? ST_OK : ST_NOT_FOUND;
				found_q   <= fhit ? 8'(fidx + IDX_W'(1)) : 8'd0;
				removed_q <= '0;
			end else begin
				status_q  <= stat_q;
				found_q   <= 8'd0;
				removed_q <= (del_q && fhit) ? fval : 32'd0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign removed_value  = removed_q;
	assign list_length    = length_q;

endmodule

// ===== rtl/core/oale_checker.sv =====
// ----------------------------------------------------------------------------
// Ordered array list engine - port checker
// Watches the top level's ports for result consistency over time.
// ----------------------------------------------------------------------------
`include "ordered_array_list_engine_unit_defines.svh"

module oale_checker import oale_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [1:0]         status,
	input logic [7:0]         found_position,
	input logic signed [31:0] removed_value,
	input logic [7:0]         list_length
);

	`OALE_ASSERT_IMP(a_fail_clean, rsp_valid && (status != ST_OK),
		(found_position == 8'd0) && (removed_value == 32'sd0))
	`OALE_ASSERT_IMP(a_full_len, rsp_valid && (status == ST_FULL),
		list_length == 8'(CAPACITY))
	`OALE_ASSERT_IMP(a_found_in_list, rsp_valid && (found_position != 8'd0),
		found_position <= list_length)
	`OALE_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(status) && $stable(list_length))

endmodule

bind ordered_array_list_engine_unit oale_checker u_oale_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Ordered array list engine - testbench
// Runs directed and random clear, locate, insert and delete requests through
// the engine under changing idle and stall patterns. A local list model works
// out the expected result of every accepted request, and the monitor checks
// each result transfer, field by field, against the oldest one waiting.
// ----------------------------------------------------------------------------
module tb;
	import oale_pkg::*;

	typedef struct {
		req_t        kind;
		logic [7:0]  pos;
		logic [31:0] val;
	} list_req_t;

	typedef struct {
		status_t     st;
		logic [7:0]  fpos;
		logic [31:0] removed;
		logic [7:0]  len;
	} list_result_t;

	typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         req_type = REQ_CLEAR;
	logic [7:0]         position = 8'd0;
	logic signed [31:0] value = 32'sd0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic [7:0]         found_position;
	logic signed [31:0] removed_value;
	logic [7:0]         list_length;

	list_req_t    request_q[$];
	list_result_t pending_results[$];
	logic [31:0]  list_mem [CAPACITY];
	int           list_len = 0;
	int           planned_len = 0;
	int           mismatch_count = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           hold_left = 0;
	bit           hold_req = 1'b0;
	bit           req_taken = 1'b0;

	ordered_array_list_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_position(found_position),
		.removed_value(removed_value),
		.list_length(list_length)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	function automatic list_result_t apply_list_request(req_t kind, logic [7:0] pos,
			logic [31:0] val);
		list_result_t r;
		int p;
		int k;
		p = int'(pos);
		r.st = ST_OK;
		r.fpos = 8'd0;
		r.removed = 32'd0;
		case (kind)
			REQ_CLEAR: begin
				list_len = 0;
			end
			REQ_LOCATE: begin
				r.st = ST_NOT_FOUND;
				for (k = 0; k < list_len && r.fpos == 8'd0; k++) begin
					if (list_mem[k] == val) begin
						r.fpos = 8'(k + 1);
						r.st = ST_OK;
					end
				end
			end
			REQ_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					r.st = ST_BAD_POS;
				end else if (list_len >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					for (k = list_len; k >= p; k--)
						list_mem[k] = list_mem[k - 1];
					list_mem[p - 1] = val;
					list_len++;
				end
			end
			default: begin
				if (p < 1 || p > list_len) begin
					r.st = ST_BAD_POS;
				end else begin
					r.removed = list_mem[p - 1];
					for (k = p; k < list_len; k++)
						list_mem[k - 1] = list_mem[k];
					list_len--;
				end
			end
		endcase
		r.len = list_len[7:0];
		return r;
	endfunction

	// request side: acceptance and prediction; result side: checking
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				pending_results.push_back(apply_list_request(req_t'(req_type), position, value));
				req_taken = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected transfer, status", 32'(status), 32'd0);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (found_position !== want.fpos)
						report_mismatch("found_position", 32'(found_position),
							32'(want.fpos));
					if (removed_value !== want.removed)
						report_mismatch("removed_value", removed_value, want.removed);
					if (list_length !== want.len)
						report_mismatch("list_length", 32'(list_length), 32'(want.len));
				end
			end
		end
	end

	always @(negedge clk) begin
		list_req_t item;
		if (arst_n && (!req_valid || req_taken)) begin
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = request_q.pop_front();
				req_valid <= 1'b1;
				req_type <= item.kind;
				position <= item.pos;
				value <= item.val;
			end else begin
				req_valid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 300;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic push_request(req_t kind, logic [7:0] pos, logic [31:0] val);
		list_req_t item;
		int p;
		p = int'(pos);
		item.kind = kind;
		item.pos = pos;
		item.val = val;
		request_q.push_back(item);
		case (kind)
			REQ_CLEAR: planned_len = 0;
			REQ_INSERT: begin
				if (p >= 1 && p <= planned_len + 1 && planned_len < CAPACITY)
					planned_len++;
			end
			REQ_DELETE: begin
				if (p >= 1 && p <= planned_len)
					planned_len--;
			end
			default: ;
		endcase
	endtask

	// small pool so that locates hit, plus the extremes
	function automatic logic [31:0] pick_value();
		if ($urandom_range(99) < 40)
			return $urandom;
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom_range(15);
		endcase
	endfunction

	task automatic push_random(int count, mix_t mix);
		int roll;
		int clr;
		int loc;
		int ins;
		case (mix)
			MIX_FILL: begin clr = 1; loc = 11; ins = 91; end
			MIX_EVEN: begin clr = 2; loc = 27; ins = 64; end
			default: begin clr = 1; loc = 16; ins = 26; end
		endcase
		repeat (count) begin
			if ($urandom_range(99) < 8) begin
				push_request(req_t'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
			end else begin
				roll = $urandom_range(99);
				if (roll < clr)
					push_request(REQ_CLEAR, 8'($urandom_range(255)), $urandom);
				else if (roll < loc)
					push_request(REQ_LOCATE, 8'($urandom_range(255)), pick_value());
				else if (roll < ins)
					push_request(REQ_INSERT, 8'($urandom_range(planned_len + 1, 1)),
						pick_value());
				else
					push_request(REQ_DELETE,
						(planned_len == 0) ? 8'd1 : 8'($urandom_range(planned_len, 1)),
						$urandom);
			end
		end
	endtask

	task automatic wait_drained();
		while (request_q.size() != 0 || req_valid || pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int b;
		push_request(REQ_LOCATE, 8'd0, 32'd5);
		push_request(REQ_DELETE, 8'd1, $urandom);
		push_request(REQ_INSERT, 8'd0, 32'd9);
		push_request(REQ_INSERT, 8'd2, 32'd9);
		push_request(REQ_INSERT, 8'd1, 32'h7fff_ffff);
		push_request(REQ_INSERT, 8'd1, 32'h8000_0000);
		push_request(REQ_INSERT, 8'd3, 32'hffff_ffff);
		push_request(REQ_INSERT, 8'd2, 32'h0000_0000);
		push_request(REQ_INSERT, 8'd255, 32'd7);
		push_request(REQ_LOCATE, 8'd255, 32'hffff_ffff);
		push_request(REQ_LOCATE, 8'd0, 32'h8000_0000);
		push_request(REQ_LOCATE, 8'd0, 32'd1);
		push_request(REQ_DELETE, 8'd0, $urandom);
		push_request(REQ_DELETE, 8'd5, $urandom);
		push_request(REQ_DELETE, 8'd2, $urandom);
		push_request(REQ_DELETE, 8'd3, $urandom);
		push_request(REQ_DELETE, 8'd1, $urandom);
		push_request(REQ_INSERT, 8'd2, 32'h55aa_55aa);
		push_request(REQ_LOCATE, 8'd128, 32'h55aa_55aa);
		push_request(REQ_CLEAR, 8'd255, 32'hffff_ffff);
		push_request(REQ_LOCATE, 8'd0, 32'h7fff_ffff);
		push_request(REQ_CLEAR, 8'd0, 32'd0);
		push_request(REQ_INSERT, 8'd1, 32'd0);
		push_request(REQ_DELETE, 8'd1, $urandom);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// no idling; fill to capacity and push against the full list
		while (planned_len < CAPACITY)
			push_random(1, MIX_FILL);
		push_random(25, MIX_FILL);
		push_random(100, MIX_EVEN);
		push_random(100, MIX_DRAIN);
		wait_drained();

		send_idle_pct = 82;
		for (b = 0; b < 4; b++)
			push_random(60, mix_t'(b % 3));
		wait_drained();

		send_idle_pct = 0;
		stall_pct = 82;
		for (b = 0; b < 4; b++)
			push_random(60, mix_t'(b % 3));
		wait_drained();

		// long receiver hold-off while requests keep coming
		send_idle_pct = 11;
		stall_pct = 11;
		hold_req = 1'b1;
		for (b = 0; b < 4; b++)
			push_random(60, mix_t'(b % 3));
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
